// ===== rtl/irtok_pkg.sv =====
// Shared types, codes and character tables for the IR text tokenizer.
// No dependencies; every other file in rtl/ imports this package.
package irtok_pkg;

  localparam int OFFSET_BITS_DEF = 20;
  localparam int FIELD_OFF_W     = 20;
  localparam int NUM_KW          = 10;
  localparam int KW_MAX_LEN      = 11;
  localparam int Q_DEPTH         = 4;

  typedef enum logic [3:0] {
    MODE_IDLE,
    MODE_COMMENT,
    MODE_SYMBOL,
    MODE_VARIABLE,
    MODE_STRING,
    MODE_ARROW,
    MODE_WORD,
    MODE_NUMBER,
    MODE_ERROR
  } scan_mode_t;

  localparam logic [4:0] KIND_INVALID  = 5'd0;
  localparam logic [4:0] KIND_SYMBOL   = 5'd1;
  localparam logic [4:0] KIND_NUMBER   = 5'd2;
  localparam logic [4:0] KIND_STRING   = 5'd3;
  localparam logic [4:0] KIND_VARIABLE = 5'd4;
  localparam logic [4:0] KIND_LPAREN   = 5'd5;
  localparam logic [4:0] KIND_RPAREN   = 5'd6;
  localparam logic [4:0] KIND_LBRACK   = 5'd7;
  localparam logic [4:0] KIND_RBRACK   = 5'd8;
  localparam logic [4:0] KIND_COMMA    = 5'd9;
  localparam logic [4:0] KIND_ARROW    = 5'd10;
  localparam logic [4:0] KIND_EQUAL    = 5'd11;
  localparam logic [4:0] KIND_PLUS     = 5'd12;
  localparam logic [4:0] KIND_KW_BASE  = 5'd13;

  localparam logic [2:0] ERR_NONE   = 3'd0;
  localparam logic [2:0] ERR_CHAR   = 3'd1;
  localparam logic [2:0] ERR_ARROW  = 3'd2;
  localparam logic [2:0] ERR_STRING = 3'd3;
  localparam logic [2:0] ERR_LONG   = 3'd4;

  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_HASH    = 8'h23;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_LPAREN  = 8'h28;
  localparam logic [7:0] CH_RPAREN  = 8'h29;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_EQUAL   = 8'h3D;
  localparam logic [7:0] CH_GT      = 8'h3E;
  localparam logic [7:0] CH_AT      = 8'h40;
  localparam logic [7:0] CH_LBRACK  = 8'h5B;
  localparam logic [7:0] CH_RBRACK  = 8'h5D;
  localparam logic [7:0] CH_UNDER   = 8'h5F;

  // Keyword text, right-justified: the first character sits in the highest used byte.
  localparam logic [KW_MAX_LEN*8-1:0] KW_TEXT [NUM_KW] = '{
    "never", "unit", "i32", "half", "word", "ptr", "add", "call", "ret",
    {"entry", CH_UNDER, "point"}
  };
  localparam logic [3:0] KW_LEN [NUM_KW] = '{
    4'd5, 4'd4, 4'd3, 4'd4, 4'd4, 4'd3, 4'd3, 4'd4, 4'd3, 4'd11
  };

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_source;
  } tok_in_t;

  typedef struct packed {
    logic [4:0]             token_kind;
    logic [2:0]             error_kind;
    logic [FIELD_OFF_W-1:0] start_offset;
    logic [FIELD_OFF_W-1:0] token_length;
    logic                   last_of_run;
  } tok_out_t;

  // Results of one byte, already packed toward the front.
  typedef struct packed {
    logic [1:0] count;
    tok_out_t   first;
    tok_out_t   second;
  } scan_res_t;

  function automatic logic is_space(input logic [7:0] b);
    return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_CR) || (b == CH_LF);
  endfunction

  function automatic logic is_alpha(input logic [7:0] b);
    return ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A));
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

  function automatic logic is_word_char(input logic [7:0] b);
    return is_alpha(b) || is_digit(b) || (b == CH_UNDER) || (b == CH_DOT);
  endfunction

  function automatic logic [4:0] single_kind(input logic [7:0] b);
    logic [4:0] k;
    unique case (b)
      CH_LPAREN: k = KIND_LPAREN;
      CH_RPAREN: k = KIND_RPAREN;
      CH_LBRACK: k = KIND_LBRACK;
      CH_RBRACK: k = KIND_RBRACK;
      CH_COMMA:  k = KIND_COMMA;
      CH_EQUAL:  k = KIND_EQUAL;
      CH_PLUS:   k = KIND_PLUS;
      default:   k = KIND_INVALID;
    endcase
    return k;
  endfunction

  // Drops every keyword that cannot match once byte b sits at position wp.
  function automatic logic [NUM_KW-1:0] kw_feed(input logic [NUM_KW-1:0] cand,
                                                input logic [3:0] wp,
                                                input logic [7:0] b);
    logic [NUM_KW-1:0] c;
    int                sh;
    c = cand;
    for (int k = 0; k < NUM_KW; k++) begin
      if (wp >= KW_LEN[k]) begin
        c[k] = 1'b0;
      end else begin
        sh = (int'(KW_LEN[k]) - 1 - int'(wp)) * 8;
        if (KW_TEXT[k][sh +: 8] != b) c[k] = 1'b0;
      end
    end
    return c;
  endfunction

  // The lowest keyword still standing whose length equals the word length wins.
  function automatic logic [4:0] word_kind(input logic [NUM_KW-1:0] cand,
                                           input logic [3:0] wp);
    logic [4:0] kind;
    kind = KIND_INVALID;
    for (int k = NUM_KW - 1; k >= 0; k--) begin
      if (cand[k] && (KW_LEN[k] == wp)) kind = KIND_KW_BASE + 5'(k);
    end
    return kind;
  endfunction

endpackage

// ===== rtl/irtok_outq.sv =====
// Result queue of the IR text tokenizer: takes up to two results a cycle, gives one.
// Depends on irtok_pkg.
module irtok_outq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [1:0]         push_cnt,
  input  irtok_pkg::tok_out_t push0,
  input  irtok_pkg::tok_out_t push1,
  output logic               has_room,
  output logic               out_valid,
  input  logic               out_ready,
  output irtok_pkg::tok_out_t out_data
);
  import irtok_pkg::*;

  localparam int PTR_W = $clog2(Q_DEPTH);
  localparam int CNT_W = $clog2(Q_DEPTH + 1);

  tok_out_t         mem_r [Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [PTR_W-1:0] wr_ptr_p1;
  logic             pop;

  assign pop       = out_valid && out_ready;
  assign wr_ptr_p1 = wr_ptr_r + PTR_W'(1);
  assign out_valid = (cnt_r != '0);
  assign out_data  = mem_r[rd_ptr_r];
  // Room for the worst case of two results from one byte.
  assign has_room  = (cnt_r <= CNT_W'(Q_DEPTH - 2));

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + PTR_W'(push_cnt);
    rd_ptr_nxt = pop ? rd_ptr_r + PTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + CNT_W'(push_cnt) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) mem_r[wr_ptr_r] <= push0;
    if (push_cnt == 2'd2) mem_r[wr_ptr_p1] <= push1;
  end

endmodule

// ===== rtl/irtok_scan.sv =====
// Scanner of the IR text tokenizer: holds the lexer state and turns one byte
// into up to two results. Depends on irtok_pkg.
module irtok_scan #(
  parameter int OFFSET_BITS = irtok_pkg::OFFSET_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  irtok_pkg::tok_in_t  in_item,
  output irtok_pkg::scan_res_t res
);
  import irtok_pkg::*;

  localparam logic [OFFSET_BITS-1:0] OFF_MAX = '1;

  scan_mode_t             mode_r, mode_nxt;
  logic [OFFSET_BITS-1:0] pos_r, pos_nxt;
  logic [OFFSET_BITS-1:0] ts_r, ts_nxt;
  logic [NUM_KW-1:0]      kwc_r, kwc_nxt;
  logic [3:0]             wpos_r, wpos_nxt;

  scan_mode_t             mode1;
  logic [OFFSET_BITS-1:0] ts1;
  logic [NUM_KW-1:0]      kwc1;
  logic [3:0]             wpos1;
  logic                   run_idle;
  logic                   e1_v, e2_v, e3_v;
  tok_out_t               e1, e2, e3;
  logic [7:0]             b;
  logic [4:0]             sk;
  logic [OFFSET_BITS-1:0] len_open, len_incl, len_last;

  function automatic tok_out_t mk(input logic [4:0] kind, input logic [2:0] err,
                                  input logic [OFFSET_BITS-1:0] start,
                                  input logic [OFFSET_BITS-1:0] len);
    tok_out_t                           t;
    logic [OFFSET_BITS+FIELD_OFF_W-1:0] s_ext, l_ext;
    s_ext          = {{FIELD_OFF_W{1'b0}}, start};
    l_ext          = {{FIELD_OFF_W{1'b0}}, len};
    t.token_kind   = kind;
    t.error_kind   = err;
    t.start_offset = s_ext[FIELD_OFF_W-1:0];
    t.token_length = l_ext[FIELD_OFF_W-1:0];
    t.last_of_run  = 1'b0;
    return t;
  endfunction

  always_comb begin
    b        = in_item.text_byte;
    sk       = single_kind(b);
    len_open = pos_r - ts_r;
    len_incl = pos_r - ts_r + OFFSET_BITS'(1);
    mode1    = mode_r;
    ts1      = ts_r;
    kwc1     = kwc_r;
    wpos1    = wpos_r;
    run_idle = 1'b0;
    e1_v     = 1'b0;
    e2_v     = 1'b0;
    e3_v     = 1'b0;
    e1       = '0;
    e2       = '0;
    e3       = '0;

    // A byte landing on the last offset drops any pending token.
    if ((mode_r != MODE_ERROR) && (pos_r == OFF_MAX)) begin
      e1_v  = 1'b1;
      e1    = mk(KIND_INVALID, ERR_LONG, pos_r, '0);
      mode1 = MODE_ERROR;
    end else begin
      unique case (mode_r)
        MODE_IDLE: run_idle = 1'b1;
        MODE_COMMENT: begin
          if (b == CH_LF) mode1 = MODE_IDLE;
        end
        MODE_SYMBOL, MODE_VARIABLE: begin
          if (is_space(b)) begin
            e1_v  = 1'b1;
            e1    = mk((mode_r == MODE_SYMBOL) ? KIND_SYMBOL : KIND_VARIABLE, ERR_NONE,
                       ts_r, len_open);
            mode1 = MODE_IDLE;
          end
        end
        MODE_STRING: begin
          if (b == CH_QUOTE) begin
            e1_v  = 1'b1;
            e1    = mk(KIND_STRING, ERR_NONE, ts_r, len_incl);
            mode1 = MODE_IDLE;
          end
        end
        MODE_ARROW: begin
          e1_v = 1'b1;
          if (b == CH_GT) begin
            e1    = mk(KIND_ARROW, ERR_NONE, ts_r, OFFSET_BITS'(2));
            mode1 = MODE_IDLE;
          end else begin
            e1    = mk(KIND_INVALID, ERR_ARROW, ts_r, '0);
            mode1 = MODE_ERROR;
          end
        end
        MODE_WORD, MODE_NUMBER: begin
          if (is_word_char(b)) begin
            if (mode_r == MODE_WORD) begin
              kwc1  = kw_feed(kwc_r, wpos_r, b);
              wpos1 = (wpos_r == 4'hF) ? wpos_r : wpos_r + 4'd1;
            end
          end else begin
            // The closing byte is then handled as if between tokens.
            e1_v     = 1'b1;
            e1       = mk((mode_r == MODE_WORD) ? word_kind(kwc_r, wpos_r) : KIND_NUMBER,
                          ERR_NONE, ts_r, len_open);
            mode1    = MODE_IDLE;
            run_idle = 1'b1;
          end
        end
        MODE_ERROR: mode1 = MODE_ERROR;
        default:    mode1 = MODE_ERROR;
      endcase
    end

    if (run_idle) begin
      ts1 = pos_r;
      priority if ((b == CH_NUL) || is_space(b)) begin
        mode1 = MODE_IDLE;
      end else if (sk != KIND_INVALID) begin
        e2_v = 1'b1;
        e2   = mk(sk, ERR_NONE, pos_r, OFFSET_BITS'(1));
      end else if (b == CH_HASH) begin
        mode1 = MODE_COMMENT;
      end else if (b == CH_AT) begin
        mode1 = MODE_SYMBOL;
      end else if (b == CH_PERCENT) begin
        mode1 = MODE_VARIABLE;
      end else if (b == CH_QUOTE) begin
        mode1 = MODE_STRING;
      end else if (b == CH_MINUS) begin
        mode1 = MODE_ARROW;
      end else if (is_alpha(b)) begin
        mode1 = MODE_WORD;
        kwc1  = kw_feed('1, 4'd0, b);
        wpos1 = 4'd1;
      end else if (is_digit(b)) begin
        mode1 = MODE_NUMBER;
      end else begin
        e2_v  = 1'b1;
        e2    = mk(KIND_INVALID, ERR_CHAR, pos_r, '0);
        mode1 = MODE_ERROR;
      end
    end

    // End of source closes whatever is still open, including this byte.
    len_last = pos_r - ts1 + OFFSET_BITS'(1);
    if (in_item.end_of_source) begin
      unique case (mode1)
        MODE_SYMBOL: begin
          e3_v = 1'b1;
          e3   = mk(KIND_SYMBOL, ERR_NONE, ts1, len_last);
        end
        MODE_VARIABLE: begin
          e3_v = 1'b1;
          e3   = mk(KIND_VARIABLE, ERR_NONE, ts1, len_last);
        end
        MODE_WORD: begin
          e3_v = 1'b1;
          e3   = mk(word_kind(kwc1, wpos1), ERR_NONE, ts1, len_last);
        end
        MODE_NUMBER: begin
          e3_v = 1'b1;
          e3   = mk(KIND_NUMBER, ERR_NONE, ts1, len_last);
        end
        MODE_STRING: begin
          e3_v = 1'b1;
          e3   = mk(KIND_INVALID, ERR_STRING, ts1, '0);
        end
        MODE_ARROW: begin
          e3_v = 1'b1;
          e3   = mk(KIND_INVALID, ERR_ARROW, ts1, '0);
        end
        default: e3_v = 1'b0;
      endcase
      mode_nxt = MODE_IDLE;
      pos_nxt  = '0;
      ts_nxt   = '0;
      kwc_nxt  = '1;
      wpos_nxt = 4'd0;
    end else begin
      mode_nxt = mode1;
      pos_nxt  = (pos_r != OFF_MAX) ? pos_r + OFFSET_BITS'(1) : pos_r;
      ts_nxt   = ts1;
      kwc_nxt  = kwc1;
      wpos_nxt = wpos1;
    end

    // At most two of the three candidates are ever present; pack them to the front.
    res.count  = 2'(e1_v) + 2'(e2_v) + 2'(e3_v);
    res.first  = e1_v ? e1 : (e2_v ? e2 : e3);
    res.second = e1_v ? (e2_v ? e2 : e3) : e3;
    if (res.count == 2'd2) begin
      res.second.last_of_run = 1'b1;
    end else begin
      res.first.last_of_run = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      pos_r  <= '0;
      ts_r   <= '0;
      kwc_r  <= '1;
      wpos_r <= 4'd0;
    end else if (fire) begin
      mode_r <= mode_nxt;
      pos_r  <= pos_nxt;
      ts_r   <= ts_nxt;
      kwc_r  <= kwc_nxt;
      wpos_r <= wpos_nxt;
    end
  end

endmodule

// ===== rtl/ir_text_tokenizer_core.sv =====
// IR text tokenizer top level: input register, scanner and result queue.
// A byte taken into the input register is scanned once the result queue has room,
// and its results go into the queue. One byte per cycle is taken while the queue has room;
// two results of one byte leave one after the other, and the four-entry queue absorbs short bursts.
// Reset (rst_n, synchronous, active low) empties the pipeline and returns the
// scanner to idle at offset zero. Depends on irtok_pkg, irtok_scan, irtok_outq.
module ir_text_tokenizer_core #(
  parameter int OFFSET_BITS = irtok_pkg::OFFSET_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  irtok_pkg::tok_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output irtok_pkg::tok_out_t out_data
);
  import irtok_pkg::*;

  logic      in_vld_r, in_vld_nxt;
  tok_in_t   in_data_r;
  scan_res_t scan_res;
  logic      q_room;
  logic      scan_fire;
  logic [1:0] push_cnt;

  // The held byte is scanned only when the queue can take both possible results.
  assign scan_fire = in_vld_r && q_room;
  assign in_ready  = !in_vld_r || scan_fire;
  assign push_cnt  = scan_fire ? scan_res.count : 2'd0;

  always_comb begin
    if (in_valid && in_ready) begin
      in_vld_nxt = 1'b1;
    end else if (scan_fire) begin
      in_vld_nxt = 1'b0;
    end else begin
      in_vld_nxt = in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) in_data_r <= in_data;
  end

  irtok_scan #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (scan_fire),
    .in_item (in_data_r),
    .res     (scan_res)
  );

  irtok_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_cnt  (push_cnt),
    .push0     (scan_res.first),
    .push1     (scan_res.second),
    .has_room  (q_room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== tb/tb_ir_text_tokenizer_core.sv =====
// Self-checking testbench for ir_text_tokenizer_core: random byte streams go in, and a
// behavioral tokenizer predicts every token and error, compared as the results arrive.
// Depends on irtok_pkg and the ir_text_tokenizer_core RTL.
module tb_ir_text_tokenizer_core;
  import irtok_pkg::*;

  // The block runs at its default offset width.
  localparam int OFFSET_BITS = OFFSET_BITS_DEF;
  localparam logic [OFFSET_BITS-1:0] POS_LIMIT = '1;
  localparam int STALL_LIMIT = 1000;

  typedef enum {BODY_SYMBOL, BODY_STRING, BODY_COMMENT} body_t;

  logic     clk;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  tok_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  tok_out_t out_data;

  tok_in_t  text_q[$];
  tok_out_t pending_tokens[$];
  tok_out_t step_buf[$];
  logic [7:0] src_buf[$];
  int       bytes_total = 0;
  int       bytes_sent = 0;
  int       fault_cnt = 0;
  int       burst_left = 0;
  int       gap_left = 0;
  int       idle_cycles = 0;
  logic [31:0] rx_cycle = 0;
  logic [15:0] stall_pat = '1;
  int       hold_left = 0;

  string kw_names[NUM_KW] = '{"never", "unit", "i32", "half", "word",
                              "ptr", "add", "call", "ret", {"entry", "_", "point"}};
  string word_set = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_.";
  string digit_set = "0123456789";
  string punct_set = "()[],=+";
  string blank_set = " \t\r\n";

  // Tokenizer state as the predictor sees it.
  scan_mode_t             sc_mode = MODE_IDLE;
  logic [OFFSET_BITS-1:0] sc_pos = '0;
  logic [OFFSET_BITS-1:0] sc_start = '0;
  logic [7:0]             sc_word[16];
  int                     sc_word_len = 0;

  ir_text_tokenizer_core #(.OFFSET_BITS(OFFSET_BITS)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic bit blank_byte(logic [7:0] b);
    return b inside {CH_SPACE, CH_TAB, CH_CR, CH_LF};
  endfunction

  function automatic bit letter_byte(logic [7:0] b);
    return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A);
  endfunction

  function automatic bit digit_byte(logic [7:0] b);
    return b >= 8'h30 && b <= 8'h39;
  endfunction

  function automatic bit ident_byte(logic [7:0] b);
    return letter_byte(b) || digit_byte(b) || b == CH_UNDER || b == CH_DOT;
  endfunction

  function automatic logic [4:0] punct_kind(logic [7:0] b);
    case (b)
      CH_LPAREN: return KIND_LPAREN;
      CH_RPAREN: return KIND_RPAREN;
      CH_LBRACK: return KIND_LBRACK;
      CH_RBRACK: return KIND_RBRACK;
      CH_COMMA:  return KIND_COMMA;
      CH_EQUAL:  return KIND_EQUAL;
      CH_PLUS:   return KIND_PLUS;
      default:   return KIND_INVALID;
    endcase
  endfunction

  function automatic void add_token(logic [4:0] kind, logic [2:0] err,
                                    longint unsigned start, longint unsigned len);
    tok_out_t r;
    r.token_kind   = kind;
    r.error_kind   = err;
    r.start_offset = FIELD_OFF_W'(start);
    r.token_length = FIELD_OFF_W'(len);
    r.last_of_run  = 1'b0;
    step_buf.push_back(r);
  endfunction

  // Word length saturates at 15, which is longer than every keyword.
  function automatic void feed_word(logic [7:0] b);
    if (sc_word_len < 15) begin
      sc_word[sc_word_len] = b;
      sc_word_len++;
    end
  endfunction

  function automatic logic [4:0] keyword_kind();
    logic [4:0] kind;
    bit         hit;
    kind = KIND_INVALID;
    for (int k = 0; k < NUM_KW; k++) begin
      if (kw_names[k].len() == sc_word_len) begin
        hit = 1'b1;
        for (int i = 0; i < sc_word_len; i++) begin
          if (kw_names[k].getc(i) != sc_word[i]) hit = 1'b0;
        end
        if (hit) kind = KIND_KW_BASE + 5'(k);
      end
    end
    return kind;
  endfunction

  // A byte seen between tokens: skip it, emit it, or open a new token with it.
  function automatic void open_token(logic [7:0] b, logic [OFFSET_BITS-1:0] p);
    sc_start = p;
    if (b == CH_NUL || blank_byte(b)) return;
    if (punct_kind(b) != KIND_INVALID) add_token(punct_kind(b), ERR_NONE, p, 1);
    else if (b == CH_HASH) sc_mode = MODE_COMMENT;
    else if (b == CH_AT) sc_mode = MODE_SYMBOL;
    else if (b == CH_PERCENT) sc_mode = MODE_VARIABLE;
    else if (b == CH_QUOTE) sc_mode = MODE_STRING;
    else if (b == CH_MINUS) sc_mode = MODE_ARROW;
    else if (letter_byte(b)) begin
      sc_mode = MODE_WORD;
      sc_word_len = 0;
      feed_word(b);
    end else if (digit_byte(b)) sc_mode = MODE_NUMBER;
    else begin
      add_token(KIND_INVALID, ERR_CHAR, p, 0);
      sc_mode = MODE_ERROR;
    end
  endfunction

  function automatic void tokenize_byte(tok_in_t it);
    logic [7:0]             b;
    logic [OFFSET_BITS-1:0] p;
    tok_out_t               tail;
    b = it.text_byte;
    p = sc_pos;
    step_buf.delete();
    if (sc_mode != MODE_ERROR && p == POS_LIMIT) begin
      add_token(KIND_INVALID, ERR_LONG, p, 0);
      sc_mode = MODE_ERROR;
    end
    case (sc_mode)
      MODE_IDLE: open_token(b, p);
      MODE_COMMENT: if (b == CH_LF) sc_mode = MODE_IDLE;
      MODE_SYMBOL, MODE_VARIABLE: if (blank_byte(b)) begin
        add_token(sc_mode == MODE_SYMBOL ? KIND_SYMBOL : KIND_VARIABLE, ERR_NONE,
                  sc_start, p - sc_start);
        sc_mode = MODE_IDLE;
      end
      MODE_STRING: if (b == CH_QUOTE) begin
        add_token(KIND_STRING, ERR_NONE, sc_start, p - sc_start + 1);
        sc_mode = MODE_IDLE;
      end
      MODE_ARROW: if (b == CH_GT) begin
        add_token(KIND_ARROW, ERR_NONE, sc_start, 2);
        sc_mode = MODE_IDLE;
      end else begin
        add_token(KIND_INVALID, ERR_ARROW, sc_start, 0);
        sc_mode = MODE_ERROR;
      end
      MODE_WORD, MODE_NUMBER: if (ident_byte(b)) begin
        if (sc_mode == MODE_WORD) feed_word(b);
      end else begin
        // The byte that ends a word or number is looked at again as a fresh byte.
        add_token(sc_mode == MODE_WORD ? keyword_kind() : KIND_NUMBER, ERR_NONE,
                  sc_start, p - sc_start);
        sc_mode = MODE_IDLE;
        open_token(b, p);
      end
      default: sc_mode = MODE_ERROR;
    endcase
    if (it.end_of_source) begin
      case (sc_mode)
        MODE_SYMBOL:   add_token(KIND_SYMBOL, ERR_NONE, sc_start, p - sc_start + 1);
        MODE_VARIABLE: add_token(KIND_VARIABLE, ERR_NONE, sc_start, p - sc_start + 1);
        MODE_WORD:     add_token(keyword_kind(), ERR_NONE, sc_start, p - sc_start + 1);
        MODE_NUMBER:   add_token(KIND_NUMBER, ERR_NONE, sc_start, p - sc_start + 1);
        MODE_STRING:   add_token(KIND_INVALID, ERR_STRING, sc_start, 0);
        MODE_ARROW:    add_token(KIND_INVALID, ERR_ARROW, sc_start, 0);
        default: ;
      endcase
      sc_mode = MODE_IDLE;
      sc_pos = '0;
      sc_start = '0;
      sc_word_len = 0;
    end else if (sc_pos != POS_LIMIT) begin
      sc_pos = sc_pos + 1'b1;
    end
    if (step_buf.size() > 0) begin
      tail = step_buf.pop_back();
      tail.last_of_run = 1'b1;
      step_buf.push_back(tail);
    end
    foreach (step_buf[i]) pending_tokens.push_back(step_buf[i]);
  endfunction

  // Stimulus construction.
  function automatic void put_text(string s);
    for (int i = 0; i < s.len(); i++) src_buf.push_back(s.getc(i));
  endfunction

  function automatic logic [7:0] pick(string s);
    return s.getc($urandom_range(0, s.len() - 1));
  endfunction

  function automatic logic [7:0] body_byte(body_t cls);
    logic [7:0] b;
    do begin
      b = ($urandom_range(0, 3) != 0) ? pick(word_set) : 8'($urandom_range(0, 255));
    end while ((cls == BODY_SYMBOL && blank_byte(b)) || (cls == BODY_STRING && b == CH_QUOTE)
               || (cls == BODY_COMMENT && b == CH_LF));
    return b;
  endfunction

  function automatic void add_piece();
    int         r;
    int         n;
    string      kw;
    logic [7:0] b;
    r = $urandom_range(0, 99);
    if (r < 14) begin
      put_text(kw_names[$urandom_range(0, NUM_KW - 1)]);
    end else if (r < 22) begin
      // Near misses: a keyword cut short, extended, or with one character changed.
      kw = kw_names[$urandom_range(0, NUM_KW - 1)];
      n = $urandom_range(0, 2);
      if (n == 0) put_text(kw.substr(0, kw.len() - 2));
      else if (n == 1) begin
        put_text(kw);
        src_buf.push_back(pick(word_set));
      end else begin
        kw.putc($urandom_range(1, kw.len() - 1), pick(word_set));
        put_text(kw);
      end
    end else if (r < 34) begin
      src_buf.push_back(pick(word_set.substr(0, 51)));
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(12, 18) : $urandom_range(0, 8);
      repeat (n) src_buf.push_back(pick(word_set));
    end else if (r < 44) begin
      src_buf.push_back(pick(digit_set));
      repeat ($urandom_range(0, 5)) src_buf.push_back(pick(word_set));
    end else if (r < 60) begin
      src_buf.push_back(r < 52 ? CH_AT : CH_PERCENT);
      repeat ($urandom_range(0, 6)) src_buf.push_back(body_byte(BODY_SYMBOL));
    end else if (r < 68) begin
      src_buf.push_back(CH_QUOTE);
      repeat ($urandom_range(0, 8)) src_buf.push_back(body_byte(BODY_STRING));
      src_buf.push_back(CH_QUOTE);
    end else if (r < 74) begin
      put_text("->");
    end else if (r < 86) begin
      src_buf.push_back(pick(punct_set));
    end else if (r < 91) begin
      src_buf.push_back(CH_HASH);
      repeat ($urandom_range(0, 8)) src_buf.push_back(body_byte(BODY_COMMENT));
      if ($urandom_range(0, 3) != 0) src_buf.push_back(CH_LF);
    end else if (r < 94) begin
      src_buf.push_back(CH_NUL);
    end else if (r < 97) begin
      src_buf.push_back(8'($urandom_range(0, 255)));
    end else begin
      // A lone minus followed by anything but the arrow head.
      do b = 8'($urandom_range(0, 255)); while (b == CH_GT);
      src_buf.push_back(CH_MINUS);
      src_buf.push_back(b);
    end
    if ($urandom_range(0, 99) < 70) begin
      repeat ($urandom_range(1, 2)) src_buf.push_back(pick(blank_set));
    end
  endfunction

  function automatic void flush_source();
    tok_in_t it;
    foreach (src_buf[i]) begin
      it.text_byte     = src_buf[i];
      it.end_of_source = (i == src_buf.size() - 1);
      text_q.push_back(it);
    end
    src_buf.delete();
  endfunction

  // A length of zero asks for a short random source.
  function automatic void queue_source(int exact_len);
    if (exact_len == 0) begin
      repeat ($urandom_range(1, 8)) add_piece();
    end else begin
      while (src_buf.size() < exact_len) add_piece();
      while (src_buf.size() > exact_len) void'(src_buf.pop_back());
    end
    flush_source();
  endfunction

  // Sender: bursts of random length with random gaps in between.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data <= '0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (in_valid && in_ready) begin
        tokenize_byte(in_data);
        bytes_sent++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0 || text_q.size() == 0) begin
          if (gap_left > 0) gap_left--;
          in_valid <= 1'b0;
        end else begin
          in_data <= text_q.pop_front();
          in_valid <= 1'b1;
          if (burst_left > 0) burst_left--;
          else begin
            burst_left = $urandom_range(0, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
    end
  end

  // Receiver: a stall pattern redrawn whenever the low six bits of the cycle count are zero,
  // plus a long hold-off, started when the low eleven bits equal 400, that backs the block up into its input.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_cycle <= 0;
      hold_left = 0;
    end else begin
      rx_cycle <= rx_cycle + 1;
      if (rx_cycle[5:0] == 6'd0) begin
        case ($urandom_range(0, 3))
          0: stall_pat <= '1;
          1: stall_pat <= 16'($urandom);
          2: stall_pat <= 16'($urandom) | 16'($urandom);
          default: stall_pat <= (16'($urandom) & 16'($urandom)) | 16'd1;
        endcase
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (rx_cycle[10:0] == 11'd400) begin
        hold_left = 150;
        out_ready <= 1'b0;
      end else begin
        out_ready <= stall_pat[rx_cycle[3:0]];
      end
    end
  end

  always @(posedge clk) begin
    tok_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_tokens.size() == 0) begin
        fault_cnt++;
        if (fault_cnt <= 10)
          $display("unexpected result at %0t: kind %0d err %0d start %0d len %0d last %0d",
                   $time, out_data.token_kind, out_data.error_kind,
                   out_data.start_offset, out_data.token_length, out_data.last_of_run);
      end else begin
        want = pending_tokens.pop_front();
        if (out_data.token_kind !== want.token_kind || out_data.error_kind !== want.error_kind
            || out_data.start_offset !== want.start_offset
            || out_data.token_length !== want.token_length
            || out_data.last_of_run !== want.last_of_run) begin
          fault_cnt++;
          if (fault_cnt <= 10) begin
            $display("mismatch at %0t (expected/actual): kind %0d/%0d err %0d/%0d",
                     $time, want.token_kind, out_data.token_kind, want.error_kind,
                     out_data.error_kind);
            $display("  start %0d/%0d len %0d/%0d last %0d/%0d",
                     want.start_offset, out_data.start_offset,
                     want.token_length, out_data.token_length,
                     want.last_of_run, out_data.last_of_run);
          end
        end
      end
    end
  end

  // Watchdog: too long without any transfer on either side ends the run.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    // Directed sources: all punctuation and the arrow, a keyword ended by a
    // punctuation byte on the final byte, a broken arrow, a skipped NUL then an
    // unhandled byte, and a symbol, string and comment cut off by end of source.
    put_text("(),[]=+->");
    flush_source();
    put_text("ret(");
    flush_source();
    put_text("-x");
    flush_source();
    src_buf.push_back(CH_NUL);
    src_buf.push_back(8'hFF);
    flush_source();
    put_text("@");
    flush_source();
    put_text("\"");
    flush_source();
    put_text("#");
    flush_source();

    repeat (12) queue_source(0);
    // One long source with many tokens in it.
    queue_source(300);
    while (text_q.size() < 900) queue_source(0);
    bytes_total = text_q.size();

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    while (bytes_sent != bytes_total) @(posedge clk);
    while (pending_tokens.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fault_cnt == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/irtok_pkg.sv
rtl/irtok_outq.sv
rtl/irtok_scan.sv
rtl/ir_text_tokenizer_core.sv
tb/tb_ir_text_tokenizer_core.sv
